FILE: rtl/spmm_pkg.sv
// ============================================================================
// spmm_pkg
// Shared types and codes for the sparse pattern matrix multiply unit.
// ============================================================================
package spmm_pkg;

    localparam int CMD_W     = 2;
    localparam int POS_W     = 3;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 4;
    localparam int STS_W     = 2;
    localparam int REG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_STORE_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STORE_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MULTIPLY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd3;

    localparam logic [REG_W-1:0] REG_RESET = 4'd8;

    typedef enum logic [STS_W-1:0] {
        STS_VALID    = 2'd0,
        STS_EMPTY    = 2'd1,
        STS_MISMATCH = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH
    } t_state;

endpackage

FILE: rtl/sparse_pattern_matrix_multiply_unit.sv
// Sparse pattern matrix multiply unit. Store commands write one bit of the A or
// B pattern and are taken one word per cycle while idle; a store reads its row
// from memory and writes it back in the next cycle, with forwarding between
// stores to the same row. A multiply stalls the input channel while it walks
// the product in row-major order: one product entry per cycle while the output
// is not stalled, set by the single read port of the B memory (kept
// transposed, one column per entry). A dimension mismatch, or an empty A row
// count or B column count, goes straight to the flush state and answers with a
// single last word. Both pattern stores read as zero after reset through
// per-row valid bits, so no clearing pass is needed.
// ============================================================================
// sparse_pattern_matrix_multiply_unit
// Bit pattern store for A and B with a memory based product walk.
// ============================================================================
module sparse_pattern_matrix_multiply_unit #(
    parameter int MAX_DIM = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input words
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [spmm_pkg::CMD_W-1:0]           i_in_command,
    input  logic [spmm_pkg::POS_W-1:0]           i_in_entry_row,
    input  logic [spmm_pkg::POS_W-1:0]           i_in_entry_col,
    input  logic signed [spmm_pkg::VAL_W-1:0]    i_in_entry_value,
    // result words
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [spmm_pkg::POS_W-1:0]           o_out_row,
    output logic [spmm_pkg::POS_W-1:0]           o_out_col,
    output logic [spmm_pkg::CNT_W-1:0]           o_out_count,
    output logic [spmm_pkg::STS_W-1:0]           o_out_status,
    output logic                                 o_out_last,
    // configuration
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [spmm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [spmm_pkg::REG_W-1:0]           i_cfg_data
);

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW = $clog2(MAX_DIM + 1);

    function automatic logic [spmm_pkg::CNT_W-1:0] popcnt(input logic [MAX_DIM-1:0] v);
        logic [spmm_pkg::CNT_W-1:0] s;
        s = '0;
        for (int k = 0; k < MAX_DIM; k++) begin
            s = s + spmm_pkg::CNT_W'(v[k]);
        end
        return s;
    endfunction

    function automatic logic [DW-1:0] eff_dim(input logic [spmm_pkg::REG_W-1:0] v);
        logic [DW-1:0] d;
        if (v > spmm_pkg::REG_W'(MAX_DIM)) d = DW'(MAX_DIM);
        else d = v[DW-1:0];
        return d;
    endfunction

    // configuration registers
    logic [spmm_pkg::REG_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [DW-1:0]              ar, ac, br, bc;

    // pattern memories: A by rows, B by columns
    logic [MAX_DIM-1:0] r_mem_a [MAX_DIM];
    logic [MAX_DIM-1:0] r_mem_b [MAX_DIM];
    logic [MAX_DIM-1:0] r_a_vld, r_b_vld;
    logic [MAX_DIM-1:0] r_a_q, r_b_q;
    logic               r_a_qv, r_b_qv;
    logic [MAX_DIM-1:0] a_row, b_col;
    logic [IW-1:0]      a_raddr, b_raddr;
    logic               a_rd, b_rd;

    // store pipeline
    logic               r_s_valid, r_s_sel, r_s_set;
    logic [IW-1:0]      r_s_addr, r_s_bit;
    logic               r_f_valid, r_f_sel;
    logic [IW-1:0]      r_f_addr;
    logic [MAX_DIM-1:0] r_f_data;
    logic               fwd;
    logic [MAX_DIM-1:0] s_base, s_mask, s_wdata;

    // walk
    spmm_pkg::t_state   r_state, n_state;
    logic [IW-1:0]      r_i, r_j;
    logic               r_iss_done, r_mis;
    logic               r_p_valid, r_p_fin;
    logic [IW-1:0]      r_p_i, r_p_j;
    logic               r_h_valid;
    logic [IW-1:0]      r_h_i, r_h_j;
    logic [spmm_pkg::CNT_W-1:0] r_h_cnt;
    logic [MAX_DIM-1:0] kmask;
    logic [spmm_pkg::CNT_W-1:0] p_cnt;
    logic               p_hit, out_free, adv, issue, i_end, j_end;

    // output register
    logic               r_o_valid, r_o_last;
    logic [spmm_pkg::POS_W-1:0] r_o_row, r_o_col;
    logic [spmm_pkg::CNT_W-1:0] r_o_cnt;
    logic [spmm_pkg::STS_W-1:0] r_o_sts;
    logic               o_load, ld_last;
    logic [spmm_pkg::POS_W-1:0] ld_row, ld_col;
    logic [spmm_pkg::CNT_W-1:0] ld_cnt;
    spmm_pkg::t_status  ld_sts;

    logic in_acc, st_a, st_b, mul, set_bit;

    assign ar = eff_dim(r_a_rows);
    assign ac = eff_dim(r_a_cols);
    assign br = eff_dim(r_b_rows);
    assign bc = eff_dim(r_b_cols);

    assign o_in_stall  = (r_state != spmm_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && (r_state == spmm_pkg::S_IDLE);
    assign set_bit     = (i_in_entry_value != '0);

    assign st_a = in_acc && (i_in_command == spmm_pkg::CMD_STORE_A)
               && (spmm_pkg::REG_W'(i_in_entry_row) < spmm_pkg::REG_W'(ar))
               && (spmm_pkg::REG_W'(i_in_entry_col) < spmm_pkg::REG_W'(ac));
    assign st_b = in_acc && (i_in_command == spmm_pkg::CMD_STORE_B)
               && (spmm_pkg::REG_W'(i_in_entry_row) < spmm_pkg::REG_W'(br))
               && (spmm_pkg::REG_W'(i_in_entry_col) < spmm_pkg::REG_W'(bc));
    assign mul  = in_acc && (i_in_command == spmm_pkg::CMD_MULTIPLY);

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= spmm_pkg::REG_RESET;
            r_a_cols <= spmm_pkg::REG_RESET;
            r_b_rows <= spmm_pkg::REG_RESET;
            r_b_cols <= spmm_pkg::REG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                spmm_pkg::CFG_A_ROWS: r_a_rows <= i_cfg_data;
                spmm_pkg::CFG_A_COLS: r_a_cols <= i_cfg_data;
                spmm_pkg::CFG_B_ROWS: r_b_rows <= i_cfg_data;
                spmm_pkg::CFG_B_COLS: r_b_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- memory ports ----
    assign a_raddr = (r_state == spmm_pkg::S_WALK) ? r_i : i_in_entry_row[IW-1:0];
    assign b_raddr = (r_state == spmm_pkg::S_WALK) ? r_j : i_in_entry_col[IW-1:0];
    assign a_rd    = st_a || issue;
    assign b_rd    = st_b || issue;
    assign a_row   = r_a_qv ? r_a_q : '0;
    assign b_col   = r_b_qv ? r_b_q : '0;

    always_ff @(posedge i_clk) begin
        if (a_rd) r_a_q <= r_mem_a[a_raddr];
        if (b_rd) r_b_q <= r_mem_b[b_raddr];
        if (r_s_valid && !r_s_sel) r_mem_a[r_s_addr] <= s_wdata;
        if (r_s_valid &&  r_s_sel) r_mem_b[r_s_addr] <= s_wdata;
    end

    // row valid bits stand in for clearing the memories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= '0;
            r_b_vld <= '0;
            r_a_qv  <= 1'b0;
            r_b_qv  <= 1'b0;
        end else begin
            if (a_rd) r_a_qv <= r_a_vld[a_raddr];
            if (b_rd) r_b_qv <= r_b_vld[b_raddr];
            if (r_s_valid && !r_s_sel) r_a_vld[r_s_addr] <= 1'b1;
            if (r_s_valid &&  r_s_sel) r_b_vld[r_s_addr] <= 1'b1;
        end
    end

    // ---- store read-modify-write ----
    // the row written last cycle was read stale by this store: forward it
    assign fwd     = r_f_valid && (r_f_sel == r_s_sel) && (r_f_addr == r_s_addr);
    assign s_base  = fwd ? r_f_data : (r_s_sel ? b_col : a_row);
    assign s_mask  = MAX_DIM'(1) << r_s_bit;
    assign s_wdata = r_s_set ? (s_base | s_mask) : (s_base & ~s_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else begin
            r_s_valid <= st_a || st_b;
            r_f_valid <= r_s_valid;
        end
        if (st_a || st_b) begin
            r_s_sel  <= st_b;
            r_s_addr <= st_b ? i_in_entry_col[IW-1:0] : i_in_entry_row[IW-1:0];
            r_s_bit  <= st_b ? i_in_entry_row[IW-1:0] : i_in_entry_col[IW-1:0];
            r_s_set  <= set_bit;
        end
        r_f_sel  <= r_s_sel;
        r_f_addr <= r_s_addr;
        r_f_data <= s_wdata;
    end

    // ---- product walk ----
    always_comb begin
        for (int k = 0; k < MAX_DIM; k++) begin
            kmask[k] = (DW'(k) < ac);
        end
    end

    assign p_cnt    = popcnt(a_row & b_col & kmask);
    assign p_hit    = (p_cnt != '0);
    assign out_free = !r_o_valid || !i_out_stall;
    // a hit pushes the held entry out, so it waits for a free output slot
    assign adv      = !(r_p_valid && p_hit && r_h_valid && !out_free);
    assign i_end    = ((DW'(r_i) + DW'(1)) == ar);
    assign j_end    = ((DW'(r_j) + DW'(1)) == bc);

    always_comb begin
        n_state = r_state;
        issue   = 1'b0;
        o_load  = 1'b0;
        ld_row  = spmm_pkg::POS_W'(r_h_i);
        ld_col  = spmm_pkg::POS_W'(r_h_j);
        ld_cnt  = r_h_cnt;
        ld_sts  = spmm_pkg::STS_VALID;
        ld_last = 1'b0;
        case (r_state)
            spmm_pkg::S_IDLE: begin
                if (mul) begin
                    if ((ac != br) || (ar == '0) || (bc == '0)) n_state = spmm_pkg::S_FLUSH;
                    else n_state = spmm_pkg::S_WALK;
                end
            end
            spmm_pkg::S_WALK: begin
                if (adv) begin
                    issue = !r_iss_done;
                    if (r_p_valid && p_hit && r_h_valid) o_load = 1'b1;
                    if (r_p_valid && r_p_fin) n_state = spmm_pkg::S_FLUSH;
                end
            end
            spmm_pkg::S_FLUSH: begin
                if (out_free) begin
                    o_load  = 1'b1;
                    ld_last = 1'b1;
                    if (r_mis || !r_h_valid) begin
                        ld_row = '0;
                        ld_col = '0;
                        ld_cnt = '0;
                        ld_sts = r_mis ? spmm_pkg::STS_MISMATCH : spmm_pkg::STS_EMPTY;
                    end
                    n_state = spmm_pkg::S_IDLE;
                end
            end
            default: n_state = spmm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= spmm_pkg::S_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid  <= 1'b0;
            r_h_valid  <= 1'b0;
            r_iss_done <= 1'b0;
            r_mis      <= 1'b0;
        end else if (mul) begin
            r_p_valid  <= 1'b0;
            r_h_valid  <= 1'b0;
            r_iss_done <= 1'b0;
            r_mis      <= (ac != br);
        end else if ((r_state == spmm_pkg::S_WALK) && adv) begin
            r_p_valid <= issue;
            if (issue && i_end && j_end) r_iss_done <= 1'b1;
            if (r_p_valid && p_hit) r_h_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul) begin
            r_i <= '0;
            r_j <= '0;
        end else if (issue) begin
            r_p_i   <= r_i;
            r_p_j   <= r_j;
            r_p_fin <= i_end && j_end;
            if (j_end) begin
                r_j <= '0;
                r_i <= r_i + IW'(1);
            end else begin
                r_j <= r_j + IW'(1);
            end
        end
        if ((r_state == spmm_pkg::S_WALK) && adv && r_p_valid && p_hit) begin
            r_h_i   <= r_p_i;
            r_h_j   <= r_p_j;
            r_h_cnt <= p_cnt;
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else if (o_load) r_o_valid <= 1'b1;
        else if (!i_out_stall) r_o_valid <= 1'b0;
        if (o_load) begin
            r_o_row  <= ld_row;
            r_o_col  <= ld_col;
            r_o_cnt  <= ld_cnt;
            r_o_sts  <= ld_sts;
            r_o_last <= ld_last;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_row    = r_o_row;
    assign o_out_col    = r_o_col;
    assign o_out_count  = r_o_cnt;
    assign o_out_status = r_o_sts;
    assign o_out_last   = r_o_last;

`ifndef NO_ASSERTIONS
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_status != spmm_pkg::STS_VALID)) |-> o_out_last)
        else $error("empty or mismatch word without last");

    a_entry_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_status == spmm_pkg::STS_VALID)) |-> (o_out_count != '0))
        else $error("product entry with zero count");

    a_pipe_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> (r_state == spmm_pkg::S_WALK))
        else $error("walk pipeline busy outside walk");

    a_store_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spmm_pkg::S_WALK) |-> !(r_s_valid && r_f_valid && $past(issue)))
        else $error("store write overlapping walk reads");
`endif

endmodule
